>>> src/dhpt_pkg.sv
// Shared types, constants and controller/datapath interface for the decaying histogram block.
package dhpt_pkg;

	localparam int DATA_W        = 32;
	localparam int DECAY_W       = 16;
	localparam int SPREAD_W      = 6;
	localparam int BIN_OUT_W     = 6;
	localparam int CFG_IDX_W     = 2;
	localparam int BIN_COUNT_DEF = 64;

	// Q16.16 increment for one counted sample
	localparam logic [DATA_W-1:0] BIN_ONE = 32'h0001_0000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_SPREAD  = 2'd3;

	// configuration reset values
	localparam logic [DATA_W-1:0]   RANGE_LOW_RST    = 32'sd0;
	localparam logic [DATA_W-1:0]   RANGE_HIGH_RST   = 32'sd1024;
	localparam logic [DECAY_W-1:0]  DECAY_FACTOR_RST = 16'd62259;
	localparam logic [SPREAD_W-1:0] PEAK_SPREAD_RST  = 6'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_IDX_GO,
		S_IDX_WAIT,
		S_DECAY_GO,
		S_DECAY,
		S_SECOND_GO,
		S_SECOND,
		S_LO_GO,
		S_LO_WAIT,
		S_HI_GO,
		S_HI_WAIT,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		DIV_INDEX,
		DIV_LOWER,
		DIV_UPPER
	} div_op_t;

	typedef enum logic {
		SCAN_DECAY,
		SCAN_SECOND
	} scan_mode_t;

	typedef struct packed {
		logic       load;
		logic       clear;
		logic       scan_start;
		scan_mode_t scan_mode;
		logic       div_start;
		div_op_t    div_op;
		logic       out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic in_range;
		logic scan_busy;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

>>> src/decaying_histogram_two_peak_threshold.sv
// Decaying histogram with two-peak threshold: top level.
//
// Requests arrive on in_valid/in_stall carrying one signed sample_value; each
// request yields exactly one result on out_valid/out_stall. A request is taken
// on a rising edge with valid high and stall low.
// Configuration (range_low, range_high, decay_factor, peak_spread) is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while the
// block is idle, which the block itself does not enforce. Per request the
// block runs one bit-serial bin-index division (only when the sample is in
// range), a decay pass over all bins, a second-peak scan and two reciprocal
// multiplications, in 16-bit chunks, for the peak values. Requests are handled
// one at a time; the next one can be taken in the cycle after the result is
// loaded. After reset a clearing pass zeroes the bin memory, during which
// in_stall stays high. A finished result sits in the output register; a new
// request is taken while it waits, and the next result is held back until the
// receiver drops out_stall.
module decaying_histogram_two_peak_threshold import dhpt_pkg::*; #(
	parameter int BIN_COUNT = BIN_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [DATA_W-1:0]    sample_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DATA_W-1:0]    threshold,
	output logic [DATA_W-1:0]    lower_peak_value,
	output logic [DATA_W-1:0]    upper_peak_value,
	output logic [BIN_OUT_W-1:0] lower_peak_bin,
	output logic [BIN_OUT_W-1:0] upper_peak_bin,
	output logic                 sample_counted
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	dhpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	dhpt_datapath #(
		.BIN_COUNT (BIN_COUNT)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.sample_value     (sample_value),
		.cmd              (cmd),
		.status           (status),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.threshold        (threshold),
		.lower_peak_value (lower_peak_value),
		.upper_peak_value (upper_peak_value),
		.lower_peak_bin   (lower_peak_bin),
		.upper_peak_bin   (upper_peak_bin),
		.sample_counted   (sample_counted)
	);

endmodule

>>> src/dhpt_div.sv
// Restoring divider, one quotient bit per cycle.
module dhpt_div import dhpt_pkg::*; #(
	parameter int NUM_W = 39,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] num_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift into the numerator register as it drains
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= denom;
			num_q <= numer;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = num_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider started while busy");

endmodule

>>> src/dhpt_datapath.sv
// Datapath: config registers, bin memory, decay/scan pipeline, divider and output register.
module dhpt_datapath import dhpt_pkg::*; #(
	parameter int BIN_COUNT = BIN_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0]     cfg_data,
	input  logic [DATA_W-1:0]     sample_value,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            status,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [DATA_W-1:0]     threshold,
	output logic [DATA_W-1:0]     lower_peak_value,
	output logic [DATA_W-1:0]     upper_peak_value,
	output logic [BIN_OUT_W-1:0]  lower_peak_bin,
	output logic [BIN_OUT_W-1:0]  upper_peak_bin,
	output logic                  sample_counted
);

	localparam int IW    = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam int BW    = $clog2(BIN_COUNT + 1);
	localparam int NUM_W = DATA_W + BW;
	localparam int XW    = IW + SPREAD_W + 1;
	localparam int PW    = DATA_W + DECAY_W;

	// reciprocal of BIN_COUNT: ceil(2^RL / BIN_COUNT) is exact for any
	// dividend below 2^PPW since 2^IW >= BIN_COUNT
	localparam int PPW = IW + DATA_W;
	localparam int RL  = PPW + IW;
	localparam int RCN = (PPW + 17) / 16;
	localparam int RCW = RCN * 16;
	localparam int AW  = PPW + 17;
	localparam int RSH = RL - 16 * (RCN - 1);
	localparam int RKW = $clog2(RCN + 1);
	localparam longint unsigned RECIP =
		((64'd1 << RL) + 64'(BIN_COUNT) - 64'd1) / 64'(BIN_COUNT);
	localparam logic [RCW-1:0] RECIP_BITS = RCW'(RECIP);

	// configuration
	logic [DATA_W-1:0]   range_low_q;
	logic [DATA_W-1:0]   range_high_q;
	logic [DECAY_W-1:0]  decay_q;
	logic [SPREAD_W-1:0] spread_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RANGE_LOW_RST;
			range_high_q <= RANGE_HIGH_RST;
			decay_q      <= DECAY_FACTOR_RST;
			spread_q     <= PEAK_SPREAD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RANGE_LOW:    range_low_q  <= cfg_data;
				CFG_RANGE_HIGH:   range_high_q <= cfg_data;
				CFG_DECAY_FACTOR: decay_q      <= cfg_data[DECAY_W-1:0];
				CFG_PEAK_SPREAD:  spread_q     <= cfg_data[SPREAD_W-1:0];
				default: ;
			endcase
		end
	end

	// sample capture: range check, offset and span
	logic [DATA_W:0]   span_full;
	logic              span_pos;
	logic              in_range;
	logic [DATA_W-1:0] diff_q;
	logic [DATA_W-1:0] span_q;
	logic              counted_q;

	assign span_full = {range_high_q[DATA_W-1], range_high_q}
	                 - {range_low_q[DATA_W-1], range_low_q};
	assign span_pos  = $signed(range_high_q) > $signed(range_low_q);
	assign in_range  = span_pos
	                 && ($signed(sample_value) >= $signed(range_low_q))
	                 && ($signed(sample_value) <  $signed(range_high_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			diff_q    <= sample_value - range_low_q;
			span_q    <= span_pos ? span_full[DATA_W-1:0] : '0;
			counted_q <= in_range;
		end
	end

	// scan address generator, shared with the clearing pass
	logic [IW-1:0] cnt_q;
	logic          issue_q;
	scan_mode_t    mode_q;
	logic          v_s1;
	logic          v_s2;
	logic          cnt_last;

	assign cnt_last = cnt_q == IW'(BIN_COUNT - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			issue_q <= 1'b0;
			mode_q  <= SCAN_DECAY;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				cnt_q   <= '0;
				issue_q <= 1'b1;
				mode_q  <= cmd.scan_mode;
			end else if (issue_q || cmd.clear) begin
				cnt_q   <= cnt_last ? '0 : cnt_q + 1'b1;
				issue_q <= issue_q && !cnt_last;
			end
			v_s1 <= issue_q;
			v_s2 <= v_s1 && (mode_q == SCAN_DECAY);
		end
	end

	// bin memory, registered read
	logic [DATA_W-1:0] bins_mem [BIN_COUNT];
	logic [DATA_W-1:0] rd_s1;
	logic [IW-1:0]     a_s1;
	logic [IW-1:0]     a_s2;
	logic [PW-1:0]     prod_s2;
	logic              mem_we;
	logic [IW-1:0]     mem_wa;
	logic [DATA_W-1:0] mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bins_mem[mem_wa] <= mem_wd;
		end
		rd_s1 <= bins_mem[cnt_q];
	end

	always_ff @(posedge clk) begin
		a_s1    <= cnt_q;
		a_s2    <= a_s1;
		prod_s2 <= rd_s1 * decay_q;
	end

	// decayed weight plus saturating increment at the target bin
	logic [IW-1:0]     target_q;
	logic [DATA_W-1:0] decayed;
	logic [DATA_W:0]   bumped;
	logic [DATA_W-1:0] new_w;
	logic              hit;

	assign decayed = prod_s2[PW-1:DECAY_W];
	assign bumped  = {1'b0, decayed} + {1'b0, BIN_ONE};
	assign hit     = counted_q && (a_s2 == target_q);
	assign new_w   = !hit ? decayed : (bumped[DATA_W] ? '1 : bumped[DATA_W-1:0]);

	assign mem_we = cmd.clear || v_s2;
	assign mem_wa = cmd.clear ? cnt_q : a_s2;
	assign mem_wd = cmd.clear ? '0 : new_w;

	// peak tracking
	logic [DATA_W-1:0] best_q;
	logic [IW-1:0]     first_q;
	logic [DATA_W-1:0] best2_q;
	logic [IW-1:0]     second_q;
	logic              found_q;
	logic [XW-1:0]     ax;
	logic [XW-1:0]     fx;
	logic [XW-1:0]     sx;
	logic              outside;

	assign ax      = XW'(a_s1);
	assign fx      = XW'(first_q);
	assign sx      = XW'(spread_q);
	assign outside = (ax + sx < fx) || (ax > fx + sx);

	always_ff @(posedge clk) begin
		if (v_s2 && ((a_s2 == '0) || (new_w > best_q))) begin
			best_q  <= new_w;
			first_q <= a_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			second_q <= '0;
			best2_q  <= '0;
		end else if (cmd.scan_start && cmd.scan_mode == SCAN_SECOND) begin
			found_q  <= 1'b0;
			second_q <= '0;
		end else if (v_s1 && mode_q == SCAN_SECOND && outside
		             && (!found_q || rd_s1 > best2_q)) begin
			found_q  <= 1'b1;
			second_q <= a_s1;
			best2_q  <= rd_s1;
		end
	end

	logic [IW-1:0] small_idx;
	logic [IW-1:0] large_idx;
	logic [IW-1:0] peak_idx;

	assign small_idx = (first_q > second_q) ? second_q : first_q;
	assign large_idx = (first_q > second_q) ? first_q : second_q;
	assign peak_idx  = (cmd.div_op == DIV_LOWER) ? small_idx : large_idx;

	// divider for the bin index; peak offsets go through the reciprocal unit
	logic [NUM_W-1:0]     dv_numer;
	logic [DATA_W-1:0]    dv_denom;
	logic [NUM_W-1:0]     dv_quot;
	logic                 dv_busy;
	logic                 dv_done;
	logic                 dv_start;
	logic [IW+DATA_W-1:0] peak_prod;
	div_op_t              op_q;
	logic [DATA_W-1:0]    qlo_q;
	logic [DATA_W-1:0]    qhi_q;

	assign peak_prod = {{DATA_W{1'b0}}, peak_idx} * {{IW{1'b0}}, span_q};
	assign dv_numer  = NUM_W'(diff_q) * NUM_W'(BIN_COUNT);
	assign dv_denom  = span_q;
	assign dv_start  = cmd.div_start && (cmd.div_op == DIV_INDEX);

	dhpt_div #(
		.NUM_W (NUM_W),
		.DEN_W (DATA_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.numer  (dv_numer),
		.denom  (dv_denom),
		.busy   (dv_busy),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	// idx*span/BIN_COUNT: multiply by the reciprocal 16 bits per cycle
	logic [PPW-1:0] rc_x_q;
	logic [RCW-1:0] rc_m_q;
	logic [AW-1:0]  rc_acc_q;
	logic [RKW-1:0] rc_cnt_q;
	logic           rc_busy_q;
	logic           rc_done_q;
	logic           rc_start;

	assign rc_start = cmd.div_start && (cmd.div_op != DIV_INDEX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_busy_q <= 1'b0;
			rc_done_q <= 1'b0;
			rc_cnt_q  <= '0;
		end else begin
			rc_done_q <= 1'b0;
			if (rc_start) begin
				rc_busy_q <= 1'b1;
				rc_cnt_q  <= RKW'(RCN);
			end else if (rc_busy_q) begin
				rc_cnt_q <= rc_cnt_q - 1'b1;
				if (rc_cnt_q == RKW'(1)) begin
					rc_busy_q <= 1'b0;
					rc_done_q <= 1'b1;
				end
			end
		end
	end

	// low bits are final once a chunk is added, so the sum shifts down as it goes
	always_ff @(posedge clk) begin
		if (rc_start) begin
			rc_x_q   <= peak_prod;
			rc_m_q   <= RECIP_BITS;
			rc_acc_q <= '0;
		end else if (rc_busy_q) begin
			rc_acc_q <= (rc_acc_q >> 16) + AW'(rc_x_q) * AW'(rc_m_q[15:0]);
			rc_m_q   <= rc_m_q >> 16;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			op_q <= cmd.div_op;
		end
		if (dv_done) begin
			target_q <= dv_quot[IW-1:0];
		end
		if (rc_done_q) begin
			case (op_q)
				DIV_LOWER: qlo_q <= rc_acc_q[RSH +: DATA_W];
				DIV_UPPER: qhi_q <= rc_acc_q[RSH +: DATA_W];
				default: ;
			endcase
		end
	end

	// result register
	logic                 out_valid_q;
	logic [DATA_W-1:0]    thr_q;
	logic [DATA_W-1:0]    vlo_q;
	logic [DATA_W-1:0]    vhi_q;
	logic [BIN_OUT_W-1:0] blo_q;
	logic [BIN_OUT_W-1:0] bhi_q;
	logic                 cnt_out_q;
	logic                 out_free;
	logic [DATA_W-1:0]    vlo;
	logic [DATA_W-1:0]    vhi;
	logic [DATA_W-1:0]    half;
	logic [IW+BIN_OUT_W-1:0] blo_ext;
	logic [IW+BIN_OUT_W-1:0] bhi_ext;

	assign out_free = !out_valid_q || !out_stall;
	assign vlo      = range_low_q + qlo_q;
	assign vhi      = range_low_q + qhi_q;
	assign half     = (qhi_q - qlo_q) >> 1;
	assign blo_ext  = {{BIN_OUT_W{1'b0}}, small_idx};
	assign bhi_ext  = {{BIN_OUT_W{1'b0}}, large_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			thr_q     <= vlo + half;
			vlo_q     <= vlo;
			vhi_q     <= vhi;
			blo_q     <= blo_ext[BIN_OUT_W-1:0];
			bhi_q     <= bhi_ext[BIN_OUT_W-1:0];
			cnt_out_q <= counted_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign threshold        = thr_q;
	assign lower_peak_value = vlo_q;
	assign upper_peak_value = vhi_q;
	assign lower_peak_bin   = blo_q;
	assign upper_peak_bin   = bhi_q;
	assign sample_counted   = cnt_out_q;

	assign status.cnt_last  = cnt_last;
	assign status.in_range  = counted_q;
	assign status.scan_busy = issue_q || v_s1 || v_s2;
	assign status.div_done  = dv_done || rc_done_q;
	assign status.out_free  = out_free;

	a_scan_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |-> !(issue_q || v_s1 || v_s2))
		else $error("scan started while a scan is in flight");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_done && op_q == DIV_INDEX) |-> (dv_quot < NUM_W'(BIN_COUNT)))
		else $error("bin index out of range");

	a_div_not_overlapped: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !(dv_busy || rc_busy_q))
		else $error("division requested while divider busy");

endmodule

>>> src/dhpt_ctrl.sv
// Controller: sequences clearing, index division, decay pass, peak scans and result handoff.
module dhpt_ctrl import dhpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:     if (status.cnt_last) state_d = S_IDLE;
			S_IDLE:      if (in_valid) state_d = S_IDX_GO;
			S_IDX_GO:    state_d = status.in_range ? S_IDX_WAIT : S_DECAY_GO;
			S_IDX_WAIT:  if (status.div_done) state_d = S_DECAY_GO;
			S_DECAY_GO:  state_d = S_DECAY;
			S_DECAY:     if (!status.scan_busy) state_d = S_SECOND_GO;
			S_SECOND_GO: state_d = S_SECOND;
			S_SECOND:    if (!status.scan_busy) state_d = S_LO_GO;
			S_LO_GO:     state_d = S_LO_WAIT;
			S_LO_WAIT:   if (status.div_done) state_d = S_HI_GO;
			S_HI_GO:     state_d = S_HI_WAIT;
			S_HI_WAIT:   if (status.div_done) state_d = S_OUT;
			S_OUT:       if (status.out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.load       = 1'b0;
		cmd.clear      = 1'b0;
		cmd.scan_start = 1'b0;
		cmd.scan_mode  = SCAN_DECAY;
		cmd.div_start  = 1'b0;
		cmd.div_op     = DIV_INDEX;
		cmd.out_load   = 1'b0;
		in_stall       = 1'b1;
		case (state_q)
			S_CLEAR: cmd.clear = 1'b1;
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_IDX_GO: cmd.div_start = status.in_range;
			S_DECAY_GO: cmd.scan_start = 1'b1;
			S_SECOND_GO: begin
				cmd.scan_start = 1'b1;
				cmd.scan_mode  = SCAN_SECOND;
			end
			S_LO_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_LOWER;
			end
			S_LO_WAIT: cmd.div_op = DIV_LOWER;
			S_HI_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_UPPER;
			end
			S_HI_WAIT: cmd.div_op = DIV_UPPER;
			S_OUT: cmd.out_load = status.out_free;
			default: ;
		endcase
	end

	a_load_to_index: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_IDX_GO)
		else $error("accepted request did not start processing");

endmodule
